// ===== design/prlf_pkg.sv =====
// Shared types and constants for the paragraph reflow line filler.
// Item structs, command codes between front and back, and character codes.
package prlf_pkg;

  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] WIDTH_RESET = 8'd75;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_t;

  typedef enum logic [1:0] {
    CMD_CHAR = 2'd0,
    CMD_SEP  = 2'd1,
    CMD_NL   = 2'd2,
    CMD_END  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e       kind;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_PENDING  = 2'd1,
    MODE_DROPPING = 2'd2
  } mode_e;

endpackage

// ===== design/prlf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/prlf_fifo.sv =====
// Small register queue with push/full and pop/empty sides.
// No dependencies; used for the command queue and the result queue.
module prlf_fifo #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== design/prlf_front.sv =====
// Front end: accepts input items and classifies each into a command.
// Depends on prlf_pkg.
module prlf_front (
  input  logic          push_i,
  input  prlf_pkg::in_t item_i,
  input  logic          cmd_full_i,
  output logic          cmd_push_o,
  output prlf_pkg::cmd_t cmd_o
);
  import prlf_pkg::*;

  assign cmd_push_o = push_i & ~cmd_full_i;

  always_comb begin
    cmd_o.data = item_i.text_byte;
    if (item_i.end_of_input) begin
      cmd_o.kind = CMD_END;
    end else if (item_i.text_byte == CH_NL) begin
      cmd_o.kind = CMD_NL;
    end else if (item_i.text_byte == CH_SPACE || item_i.text_byte == CH_TAB) begin
      cmd_o.kind = CMD_SEP;
    end else begin
      cmd_o.kind = CMD_CHAR;
    end
  end

endmodule

// ===== design/prlf_back.sv =====
// Back end: word store, column and newline tracking, and byte emission.
// Depends on prlf_pkg and prlf_ram.
module prlf_back #(
  parameter int WORD_MAX = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     line_width_i,
  input  prlf_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  output prlf_pkg::out_t out_item_o,
  output logic           out_push_o,
  input  logic           out_full_i
);
  import prlf_pkg::*;

  localparam int AW    = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;
  localparam int LEN_W = $clog2(WORD_MAX + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SEP  = 4'b0010,
    ST_WORD = 4'b0100,
    ST_TAIL = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [LEN_W-1:0] len_q, len_d, wlen_q, wlen_d;
  logic [7:0]       col_q, col_d;
  mode_e            mode_q, mode_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [1:0]       tail_q, tail_d;
  logic [7:0]       sep_q, sep_d;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;

  prlf_ram #(
    .WIDTH(8),
    .DEPTH(WORD_MAX)
  ) u_word_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(len_q)),
    .wdata_i(cmd_i.data),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    logic       flush;
    logic       fits;
    logic [8:0] sum;
    logic [7:0] col_f;
    logic       last_byte;

    state_d    = state_q;
    len_d      = len_q;
    wlen_d     = wlen_q;
    col_d      = col_q;
    mode_d     = mode_q;
    idx_d      = idx_q;
    tail_d     = tail_q;
    sep_d      = sep_q;
    cmd_pop_o  = 1'b0;
    out_push_o = 1'b0;
    out_item_o.out_byte    = ram_rdata;
    out_item_o.last_of_run = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = idx_q;

    flush     = (cmd_i.kind != CMD_CHAR) && (len_q != '0);
    sum       = {1'b0, col_q} + 9'd1 + 9'(len_q);
    fits      = (sum <= {1'b0, line_width_i});
    col_f     = col_q;
    last_byte = (LEN_W'(idx_q) == wlen_q - 1'b1);
    if (flush) begin
      col_f = (col_q != '0 && fits) ? sum[7:0] : 8'(len_q);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          tail_d    = 2'd0;
          case (cmd_i.kind)
            CMD_END: begin
              tail_d = (col_f != '0) ? 2'd1 : 2'd0;
              col_d  = '0;
              mode_d = MODE_NORMAL;
            end
            CMD_NL: begin
              col_d = col_f;
              if (mode_q == MODE_PENDING) begin
                tail_d = (col_f != '0) ? 2'd2 : 2'd1;
                col_d  = '0;
                mode_d = MODE_DROPPING;
              end else if (mode_q != MODE_DROPPING) begin
                mode_d = MODE_PENDING;
              end
            end
            CMD_SEP: begin
              col_d  = col_f;
              mode_d = MODE_NORMAL;
            end
            default: begin
              mode_d = MODE_NORMAL;
              if (len_q < LEN_W'(WORD_MAX)) begin
                ram_we = 1'b1;
                len_d  = len_q + 1'b1;
              end
            end
          endcase
          if (flush) begin
            wlen_d    = len_q;
            len_d     = '0;
            idx_d     = '0;
            ram_re    = 1'b1;
            ram_raddr = '0;
            sep_d     = fits ? CH_SPACE : CH_NL;
            state_d   = (col_q != '0) ? ST_SEP : ST_WORD;
          end else if (tail_d != 2'd0) begin
            state_d = ST_TAIL;
          end
        end
      end
      ST_SEP: begin
        out_item_o.out_byte = sep_q;
        if (!out_full_i) begin
          out_push_o = 1'b1;
          state_d    = ST_WORD;
        end
      end
      ST_WORD: begin
        out_item_o.last_of_run = last_byte && (tail_q == 2'd0);
        if (!out_full_i) begin
          out_push_o = 1'b1;
          if (last_byte) begin
            state_d = (tail_q != 2'd0) ? ST_TAIL : ST_IDLE;
          end else begin
            idx_d     = idx_q + 1'b1;
            ram_re    = 1'b1;
            ram_raddr = idx_q + 1'b1;
          end
        end
      end
      ST_TAIL: begin
        out_item_o.out_byte    = CH_NL;
        out_item_o.last_of_run = (tail_q == 2'd1);
        if (!out_full_i) begin
          out_push_o = 1'b1;
          tail_d     = tail_q - 1'b1;
          if (tail_q == 2'd1) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      wlen_q  <= '0;
      col_q   <= '0;
      mode_q  <= MODE_NORMAL;
      idx_q   <= '0;
      tail_q  <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      wlen_q  <= wlen_d;
      col_q   <= col_d;
      mode_q  <= mode_d;
      idx_q   <= idx_d;
      tail_q  <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sep_q <= sep_d;
  end

endmodule

// ===== design/paragraph_reflow_line_filler_unit.sv =====
// Greedy paragraph reflow: one text byte or end marker per input item, reflowed
// bytes out. The front accepts one item per cycle, unless full is raised, into a
// CMD_DEPTH-entry command queue; the back pops a command only after it has written
// every byte of the previous one, one byte per cycle while the OUT_DEPTH-entry
// result queue is not full. A word, held in a WORD_MAX-byte RAM, is written out when
// a space, tab, newline or end marker ends it.
// Depends on prlf_pkg, prlf_front, prlf_fifo and prlf_back.
module paragraph_reflow_line_filler_unit #(
  parameter int WORD_MAX  = 32,
  parameter int CMD_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  prlf_pkg::in_t  in_item_i,
  output logic           empty,
  input  logic           pop,
  output prlf_pkg::out_t out_item_o,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i
);
  import prlf_pkg::*;

  logic [7:0] line_width_q;
  logic       cmd_push, cmd_pop, cmd_empty;
  cmd_t       cmd_in, cmd_out;
  logic       out_push, out_full;
  out_t       out_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= WIDTH_RESET;
    end else if (cfg_we_i) begin
      line_width_q <= cfg_wdata_i;
    end
  end

  prlf_front u_front (
    .push_i    (push),
    .item_i    (in_item_i),
    .cmd_full_i(full),
    .cmd_push_o(cmd_push),
    .cmd_o     (cmd_in)
  );

  prlf_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (full),
    .pop_i  (cmd_pop),
    .data_o (cmd_out),
    .empty_o(cmd_empty)
  );

  prlf_back #(
    .WORD_MAX(WORD_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .line_width_i(line_width_q),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .out_item_o  (out_in),
    .out_push_o  (out_push),
    .out_full_i  (out_full)
  );

  prlf_fifo #(
    .WIDTH($bits(out_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (out_in),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (out_item_o),
    .empty_o(empty)
  );

endmodule

// ===== design/prlf_checker.sv =====
// Port-level checks for the reflow unit, bound to the top level.
// Depends on prlf_pkg.
module prlf_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           empty,
  input logic           pop,
  input prlf_pkg::out_t out_item_o
);
  import prlf_pkg::*;

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_item_o))
    else $error("waiting result changed");

  a_no_tab_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_item_o.out_byte != CH_TAB)
    else $error("tab reached the output");

  a_space_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.last_of_run |-> out_item_o.out_byte != CH_SPACE)
    else $error("run ended on a separator space");

  a_space_not_after_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop && out_item_o.out_byte == CH_SPACE |=>
      empty || out_item_o.out_byte != CH_SPACE)
    else $error("two spaces in a row");

endmodule

bind paragraph_reflow_line_filler_unit prlf_checker u_prlf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);

// ===== dv/tb.sv =====
// Testbench for paragraph_reflow_line_filler_unit: random and directed text through the reflow.
// A tracker class predicts every output byte and checks each popped item in order.
// Depends on prlf_pkg and the design files of the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prlf_pkg::*;

  localparam int WORD_MAX = 32;
  localparam int SETTLE   = 64;
  localparam int HOLD_LEN = 300;

  class reflow_tracker;
    logic [7:0]  width;
    logic [7:0]  word_buf [WORD_MAX];
    int unsigned word_len;
    logic [7:0]  column;
    mode_e       nl_mode;
    out_t        expected_bytes[$];
    out_t        run[$];
    int          mismatches;

    function new();
      width = WIDTH_RESET;
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      word_len = 0;
      column = '0;
      nl_mode = MODE_NORMAL;
    endfunction

    function void put(logic [7:0] b);
      out_t o;
      o.out_byte = b;
      o.last_of_run = 1'b0;
      run.push_back(o);
    endfunction

    function void flush_word();
      if (word_len == 0) return;
      if (column == 0) begin
        column = 8'(word_len);
      end else if (int'(column) + 1 + word_len <= int'(width)) begin
        put(CH_SPACE);
        column = 8'(int'(column) + 1 + word_len);
      end else begin
        put(CH_NL);
        column = 8'(word_len);
      end
      for (int i = 0; i < word_len; i++) put(word_buf[i]);
      word_len = 0;
    endfunction

    function void take_item(in_t it);
      out_t tail;
      run.delete();
      if (it.end_of_input) begin
        flush_word();
        if (column > 0) put(CH_NL);
        clear();
      end else if (it.text_byte == CH_NL) begin
        flush_word();
        if (nl_mode == MODE_PENDING) begin
          if (column > 0) begin
            put(CH_NL);
            column = '0;
          end
          put(CH_NL);
          nl_mode = MODE_DROPPING;
        end else if (nl_mode != MODE_DROPPING) begin
          nl_mode = MODE_PENDING;
        end
      end else begin
        nl_mode = MODE_NORMAL;
        if (it.text_byte == CH_SPACE || it.text_byte == CH_TAB) begin
          flush_word();
        end else if (word_len < WORD_MAX) begin
          word_buf[word_len] = it.text_byte;
          word_len++;
        end
      end
      if (run.size() > 0) begin
        tail = run.pop_back();
        tail.last_of_run = 1'b1;
        run.push_back(tail);
      end
      foreach (run[i]) expected_bytes.push_back(run[i]);
    endfunction

    function void match_byte(out_t got);
      out_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected item: out_byte %h last_of_run %b", got.out_byte, got.last_of_run);
        mismatches++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %b, actual %b", want.last_of_run, got.last_of_run);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  in_t        in_item = '0;
  logic       empty;
  logic       pop = 1'b0;
  out_t       out_item;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  reflow_tracker tracker;
  int  sender_idle_pct = 0;
  int  receiver_idle_pct = 0;
  int  items_sent = 0;
  bit  hold_req = 1'b0;

  paragraph_reflow_line_filler_unit #(
    .WORD_MAX(WORD_MAX)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [7:0] pick_letter();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == CH_SPACE || b == CH_TAB || b == CH_NL);
    return b;
  endfunction

  task automatic send_item(in_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk_i);
    while (full);
    tracker.take_item(it);
    items_sent++;
  endtask

  task automatic send_char(logic [7:0] b);
    in_t it;
    it.text_byte = b;
    it.end_of_input = 1'b0;
    send_item(it);
  endtask

  task automatic send_end();
    in_t it;
    it.text_byte = 8'($urandom_range(255));
    it.end_of_input = 1'b1;
    send_item(it);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_char(s[i]);
  endtask

  // hold the input until every expected item is out and the block is quiet, then set the new width
  task automatic retune(logic [7:0] w);
    push <= 1'b0;
    do @(posedge clk_i);
    while (tracker.expected_bytes.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    tracker.width = w;
  endtask

  task automatic run_text(int n);
    int target;
    int len;
    int r;
    target = items_sent + n;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 6) begin
        send_char(8'($urandom_range(255)));
      end else if (r < 9) begin
        send_end();
      end else begin
        len = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        repeat (len) send_char(pick_letter());
        r = $urandom_range(99);
        if (r < 50) begin
          send_char(CH_SPACE);
        end else if (r < 65) begin
          send_char(CH_TAB);
        end else if (r < 85) begin
          send_char(CH_NL);
        end else if (r < 95) begin
          repeat (2) send_char(CH_NL);
        end else begin
          repeat (3) send_char(CH_NL);
        end
      end
    end
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_LEN;
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= ($urandom_range(99) >= receiver_idle_pct);
      end
      @(posedge clk_i);
      if (pop && !empty) tracker.match_byte(out_item);
    end
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    tracker = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 7;
    receiver_idle_pct = 64;
    retune(8'd3);
    send_text("ab cd\tefgh\n\n\n");
    send_text("xyzw");
    send_char(8'hFF);
    send_char(8'h00);
    send_char(CH_SPACE);
    send_end();
    send_char("z");
    send_end();

    retune(8'd255);
    run_text(100);

    sender_idle_pct = 64;
    receiver_idle_pct = 7;
    retune(8'd0);
    run_text(60);
    retune(8'd1);
    run_text(60);

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    retune(8'($urandom_range(10, 80)));
    hold_req = 1'b1;
    run_text(70);
    retune(WIDTH_RESET);
    run_text(100);

    push <= 1'b0;
    do @(posedge clk_i);
    while (tracker.expected_bytes.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/prlf_pkg.sv
design/prlf_ram.sv
design/prlf_fifo.sv
design/prlf_front.sv
design/prlf_back.sv
design/paragraph_reflow_line_filler_unit.sv
design/prlf_checker.sv
dv/tb.sv
